// File: src/smbq_pkg.sv
// ----------------------------------------------------------------------------
// smbq_pkg: shared types and constants
// Register indexes, channel modes and lane control for the mid/side biquad.
// ----------------------------------------------------------------------------
`default_nettype none
package smbq_pkg;
  localparam int REG_W = 32;
  localparam int IDX_W = 3;
  localparam int FRAC = 24;

  localparam logic [IDX_W-1:0] REG_ENABLED = 3'd0;
  localparam logic [IDX_W-1:0] REG_MODE    = 3'd1;
  localparam logic [IDX_W-1:0] REG_STAGES  = 3'd2;
  localparam logic [IDX_W-1:0] REG_B0      = 3'd3;
  localparam logic [IDX_W-1:0] REG_B1      = 3'd4;
  localparam logic [IDX_W-1:0] REG_B2      = 3'd5;
  localparam logic [IDX_W-1:0] REG_A1      = 3'd6;
  localparam logic [IDX_W-1:0] REG_A2      = 3'd7;

  localparam logic [2:0] MODE_STEREO = 3'd0;
  localparam logic [2:0] MODE_LEFT   = 3'd1;
  localparam logic [2:0] MODE_RIGHT  = 3'd2;
  localparam logic [2:0] MODE_MID    = 3'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_MERGE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       start;
    logic [2:0] stages;
  } lane_ctl_t;
endpackage
`default_nettype wire

// File: src/stereo_midside_biquad_cascade_top.sv
// ----------------------------------------------------------------------------
// stereo_midside_biquad_cascade_top: stereo / mid-side biquad cascade
// Two serial-MAC lanes (left or mid, right or side) and a merge stage.
// ----------------------------------------------------------------------------
// Each lane has a single multiplier doing five taps per stage, one tap per cycle.
// A new pair is taken only once the previous result is in the output register.
// Reset clears config to defaults and all stage history to zero at once.
// The input takes a new pair while a finished result waits in the output register.
`default_nettype none
module stereo_midside_biquad_cascade_top
  import smbq_pkg::*;
#(
  parameter int MAX_STAGES   = 4,
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 32
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire logic [IDX_W-1:0]         cfg_index,
  input  wire logic [REG_W-1:0]         cfg_data,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0] left_in,
  input  wire logic signed [SAMPLE_WIDTH-1:0] right_in,
  input  wire                           block_end,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] left_out,
  output logic signed [SAMPLE_WIDTH-1:0] right_out,
  output logic                          block_end_out
);
  localparam int CW = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;
  localparam int SW = SAMPLE_WIDTH;

  logic       enabled;
  logic [2:0] channel_mode, stage_count;
  logic [REG_W-1:0] cb0, cb1, cb2, ca1, ca2;
  logic signed [COEF_WIDTH-1:0] b0, b1, b2, a1, a2;

  always_comb begin
    b0 = COEF_WIDTH'($signed(cb0[CW-1:0]));
    b1 = COEF_WIDTH'($signed(cb1[CW-1:0]));
    b2 = COEF_WIDTH'($signed(cb2[CW-1:0]));
    a1 = COEF_WIDTH'($signed(ca1[CW-1:0]));
    a2 = COEF_WIDTH'($signed(ca2[CW-1:0]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0; channel_mode <= MODE_STEREO; stage_count <= 3'd1;
      cb0 <= REG_W'(32'd16777216); cb1 <= '0; cb2 <= '0; ca1 <= '0; ca2 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLED: enabled      <= cfg_data[0];
        REG_MODE:    channel_mode <= cfg_data[2:0];
        REG_STAGES:  stage_count  <= cfg_data[2:0];
        REG_B0:      cb0 <= cfg_data;
        REG_B1:      cb1 <= cfg_data;
        REG_B2:      cb2 <= cfg_data;
        REG_A1:      ca1 <= cfg_data;
        default:     ca2 <= cfg_data;
      endcase
    end
  end

  state_t state, state_next;
  logic signed [SW-1:0] l_r, r_r, mid_r, side_r, ya, yb;
  logic par_r, be_r, filt, busy_a, busy_b, merge_en, load, go_a, go_b, start;
  logic [2:0] n_eff, mode_r;
  logic signed [SW:0] sum, dif;
  lane_ctl_t ctl_a, ctl_b;

  always_comb begin
    sum = (SW+1)'(left_in) + (SW+1)'(right_in);
    dif = (SW+1)'(left_in) - (SW+1)'(right_in);
    if (stage_count == 3'd0) n_eff = 3'd1;
    else if ({1'b0, stage_count} > 4'(MAX_STAGES)) n_eff = 3'(MAX_STAGES);
    else n_eff = stage_count;
  end

  assign in_ready = (state == ST_IDLE);
  assign start    = in_valid && in_ready;
  assign go_a = start && enabled && (channel_mode == MODE_STEREO ||
                channel_mode == MODE_LEFT || channel_mode == MODE_MID);
  assign go_b = start && enabled && !(channel_mode == MODE_LEFT ||
                channel_mode == MODE_MID);
  assign ctl_a = '{start: go_a, stages: n_eff};
  assign ctl_b = '{start: go_b, stages: n_eff};
  assign merge_en = (state == ST_MERGE);
  assign load     = merge_en && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (start) begin
      l_r <= left_in; r_r <= right_in; be_r <= block_end;
      mid_r <= sum[SW:1]; side_r <= dif[SW:1]; par_r <= sum[0];
      filt <= enabled; mode_r <= channel_mode;
    end
  end

  smbq_lane #(.MAX_STAGES(MAX_STAGES), .SAMPLE_WIDTH(SW), .COEF_WIDTH(COEF_WIDTH))
  u_lane_a (.clk, .rst, .ctl(ctl_a), .x_in(channel_mode == MODE_MID ? sum[SW:1] : left_in),
    .b0, .b1, .b2, .a1, .a2, .y(ya), .busy(busy_a));

  smbq_lane #(.MAX_STAGES(MAX_STAGES), .SAMPLE_WIDTH(SW), .COEF_WIDTH(COEF_WIDTH))
  u_lane_b (.clk, .rst, .ctl(ctl_b), .x_in(channel_mode >= 3'd3 ? dif[SW:1] : right_in),
    .b0, .b1, .b2, .a1, .a2, .y(yb), .busy(busy_b));

  smbq_merge #(.SAMPLE_WIDTH(SW)) u_merge (
    .clk, .en(load), .filt, .mode(mode_r), .l_in(l_r), .r_in(r_r),
    .mid_in(mid_r), .side_in(side_r), .par(par_r), .ya, .yb,
    .l_out(left_out), .r_out(right_out));

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_RUN;
      ST_RUN:   if (!busy_a && !busy_b) state_next = ST_MERGE;
      ST_MERGE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) block_end_out <= be_r;
  end
endmodule
`default_nettype wire

// File: src/smbq_lane.sv
// ----------------------------------------------------------------------------
// smbq_lane: one biquad cascade lane
// Serial MAC over five taps per stage with its own stage history.
// ----------------------------------------------------------------------------
`default_nettype none
module smbq_lane
  import smbq_pkg::*;
#(
  parameter int MAX_STAGES   = 4,
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 32
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire lane_ctl_t                 ctl,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x_in,
  input  wire logic signed [COEF_WIDTH-1:0]   b0,
  input  wire logic signed [COEF_WIDTH-1:0]   b1,
  input  wire logic signed [COEF_WIDTH-1:0]   b2,
  input  wire logic signed [COEF_WIDTH-1:0]   a1,
  input  wire logic signed [COEF_WIDTH-1:0]   a2,
  output logic signed [SAMPLE_WIDTH-1:0] y,
  output logic                           busy
);
  localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int CPW = COEF_WIDTH + 1;
  localparam int PW = CPW + SAMPLE_WIDTH;
  localparam int AW = PW + 3;
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FRAC - 1);
  localparam logic signed [AW-1:0] SMAX = AW'((64'sd1 <<< (SAMPLE_WIDTH-1)) - 1);
  localparam logic signed [AW-1:0] SMIN = -SMAX - AW'(1);

  logic signed [SAMPLE_WIDTH-1:0] x1 [MAX_STAGES];
  logic signed [SAMPLE_WIDTH-1:0] x2 [MAX_STAGES];
  logic signed [SAMPLE_WIDTH-1:0] y1 [MAX_STAGES];
  logic signed [SAMPLE_WIDTH-1:0] y2 [MAX_STAGES];

  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [AW-1:0]           acc;
  logic signed [PW-1:0]           prod;
  logic [SW-1:0]                  stage;
  logic [2:0]                     last;
  logic [2:0]                     tap;
  logic                           prod_ok;

  // one bit wider so that negating the most negative coefficient stays exact
  logic signed [CPW-1:0]          c_sel;
  logic signed [SAMPLE_WIDTH-1:0] d_sel;
  logic signed [AW-1:0]           rounded;
  logic signed [SAMPLE_WIDTH-1:0] sat;
  logic signed [AW-1:0]           acc_fin;

  always_comb begin
    case (tap)
      3'd0:    begin c_sel = CPW'(b0); d_sel = x; end
      3'd1:    begin c_sel = CPW'(b1); d_sel = x1[stage]; end
      3'd2:    begin c_sel = CPW'(b2); d_sel = x2[stage]; end
      3'd3:    begin c_sel = -(CPW'(a1)); d_sel = y1[stage]; end
      default: begin c_sel = -(CPW'(a2)); d_sel = y2[stage]; end
    endcase
    acc_fin = acc + AW'(prod);
    rounded = (acc_fin + HALF) >>> FRAC;
    if (rounded > SMAX) sat = SMAX[SAMPLE_WIDTH-1:0];
    else if (rounded < SMIN) sat = SMIN[SAMPLE_WIDTH-1:0];
    else sat = rounded[SAMPLE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      prod_ok <= 1'b0;
      tap     <= '0;
      stage   <= '0;
      for (int i = 0; i < MAX_STAGES; i++) begin
        x1[i] <= '0; x2[i] <= '0; y1[i] <= '0; y2[i] <= '0;
      end
    end else if (ctl.start) begin
      busy    <= 1'b1;
      prod_ok <= 1'b0;
      tap     <= '0;
      stage   <= '0;
      last    <= ctl.stages;
      x       <= x_in;
      acc     <= '0;
    end else if (busy) begin
      prod    <= PW'(c_sel * d_sel);
      if (tap == 3'd5) begin
        x2[stage] <= x1[stage];
        x1[stage] <= x;
        y2[stage] <= y1[stage];
        y1[stage] <= sat;
        x         <= sat;
        y         <= sat;
        acc       <= '0;
        tap       <= '0;
        prod_ok   <= 1'b0;
        if ({1'b0, stage} + 4'd1 >= {1'b0, last}) busy <= 1'b0;
        else stage <= stage + SW'(1);
      end else begin
        tap     <= tap + 3'd1;
        prod_ok <= 1'b1;
        if (prod_ok) acc <= acc_fin;
      end
    end
  end
endmodule
`default_nettype wire

// File: src/smbq_merge.sv
// ----------------------------------------------------------------------------
// smbq_merge: mid/side recombination and output select
// Combines the lane results into the output pair per channel mode.
// ----------------------------------------------------------------------------
`default_nettype none
module smbq_merge
  import smbq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire                                  clk,
  input  wire                                  en,
  input  wire                                  filt,
  input  wire logic [2:0]                      mode,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  l_in,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  r_in,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  mid_in,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  side_in,
  input  wire logic                            par,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  ya,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  yb,
  output logic signed [SAMPLE_WIDTH-1:0]       l_out,
  output logic signed [SAMPLE_WIDTH-1:0]       r_out
);
  localparam int W = SAMPLE_WIDTH + 2;
  localparam logic signed [W-1:0] SMAX = W'((64'sd1 <<< (SAMPLE_WIDTH-1)) - 1);
  localparam logic signed [W-1:0] SMIN = -SMAX - W'(1);

  logic signed [SAMPLE_WIDTH-1:0] m, s, l_n, r_n;
  logic signed [W-1:0] lsum, rdif;

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat(input logic signed [W-1:0] v);
    if (v > SMAX) return SMAX[SAMPLE_WIDTH-1:0];
    if (v < SMIN) return SMIN[SAMPLE_WIDTH-1:0];
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  always_comb begin
    m = (mode == MODE_MID) ? ya : mid_in;
    s = (mode == MODE_MID) ? side_in : yb;
    lsum = W'(m) + W'(s) + W'({1'b0, par});
    rdif = W'(m) - W'(s);
    l_n = l_in;
    r_n = r_in;
    if (filt) begin
      case (mode)
        MODE_STEREO: begin l_n = ya; r_n = yb; end
        MODE_LEFT:   l_n = ya;
        MODE_RIGHT:  r_n = yb;
        default: begin l_n = sat(lsum); r_n = sat(rdif); end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_out <= l_n;
      r_out <= r_n;
    end
  end
endmodule
`default_nettype wire

// File: src/smbq_checker.sv
// ----------------------------------------------------------------------------
// smbq_checker: port-level checks
// Handshake, ordering and reset checks on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module smbq_checker (
  input wire clk,
  input wire rst,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire block_end_out
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(block_end_out))
    else $error("output changed while stalled");
  a_no_ready_after: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind stereo_midside_biquad_cascade_top smbq_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .block_end_out);
`default_nettype wire
